>>> src/membrane_vertex_energy_macros.svh
// assertion macros for the membrane vertex energy block
// used by the port checker; no other dependencies
`ifndef MEMBRANE_VERTEX_ENERGY_MACROS_SVH
`define MEMBRANE_VERTEX_ENERGY_MACROS_SVH

// same-cycle implication
`define MVE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("membrane_vertex_energy: implication check failed");

// next-cycle implication
`define MVE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("membrane_vertex_energy: next-cycle check failed");

`endif

>>> src/mve_pkg.sv
// shared types, constants and the microcode table of the vertex energy block
// no dependencies
package mve_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_HALF = 3'd3,
    OP_TST  = 3'd4,
    OP_TOR  = 3'd5,
    OP_END  = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
    logic       ctype;  // 0 global word, 1 per-type word
    logic [3:0] coff;
    logic       guard;  // skipped when the test flag is clear
  } instr_t;

  // operand codes: 0..15 scratch slots
  localparam logic [4:0] S0  = 5'd0;
  localparam logic [4:0] S1  = 5'd1;
  localparam logic [4:0] S2  = 5'd2;
  localparam logic [4:0] S3  = 5'd3;
  localparam logic [4:0] S4  = 5'd4;
  localparam logic [4:0] S5  = 5'd5;
  localparam logic [4:0] S6  = 5'd6;
  localparam logic [4:0] S7  = 5'd7;
  localparam logic [4:0] S8  = 5'd8;
  localparam logic [4:0] S9  = 5'd9;
  localparam logic [4:0] S10 = 5'd10;
  localparam logic [4:0] O_C1 = 5'd16;
  localparam logic [4:0] O_C2 = 5'd17;
  localparam logic [4:0] O_SZ = 5'd18;
  localparam logic [4:0] O_DC = 5'd19;
  localparam logic [4:0] O_DS = 5'd20;
  localparam logic [4:0] O_FC = 5'd21;
  localparam logic [4:0] O_CF = 5'd22;

  localparam logic CG = 1'b0;
  localparam logic CT = 1'b1;
  localparam logic NG = 1'b0;
  localparam logic GD = 1'b1;

  localparam logic [3:0] G_KAPPA   = 4'd0;
  localparam logic [3:0] G_KAPPAG  = 4'd1;
  localparam logic [3:0] G_C0      = 4'd2;
  localparam logic [3:0] G_KVA     = 4'd3;
  localparam logic [3:0] G_AV0     = 4'd4;
  localparam logic [3:0] G_FIELD   = 4'd5;
  localparam logic [3:0] G_LAMBDA  = 4'd6;
  localparam logic [3:0] G_KGEDGE  = 4'd7;
  localparam logic [3:0] G_KNEDGE  = 4'd8;
  localparam logic [3:0] G_KVAEDGE = 4'd9;
  localparam logic [3:0] G_AV0EDGE = 4'd10;
  localparam logic [3:0] T_K       = 4'd0;
  localparam logic [3:0] T_KG      = 4'd1;
  localparam logic [3:0] T_K1      = 4'd2;
  localparam logic [3:0] T_K2      = 4'd3;
  localparam logic [3:0] T_C0      = 4'd4;
  localparam logic [3:0] T_C1      = 4'd5;
  localparam logic [3:0] T_C2      = 4'd6;
  localparam logic [3:0] T_ELAMBDA = 4'd7;
  localparam logic [3:0] T_EKN     = 4'd9;
  localparam logic [3:0] T_ECN     = 4'd10;
  localparam logic [3:0] C_NONE    = 4'd0;

  localparam logic [6:0] PC_SURF     = 7'd0;
  localparam logic [6:0] PC_SURF_INC = 7'd14;
  localparam logic [6:0] PC_EDGE     = 7'd53;
  localparam logic [6:0] PC_EDGE_INC = 7'd66;

  localparam logic signed [63:0] LIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  localparam int COEF_DEPTH = 256;
  localparam int SLOT_DEPTH = 16;

  function automatic instr_t mk(input op_t op, input logic [4:0] dst, input logic [4:0] sa,
                                input logic [4:0] sb, input logic ct, input logic [3:0] co,
                                input logic g);
    instr_t r;
    r.op    = op;
    r.dst   = dst[3:0];
    r.sa    = sa;
    r.sb    = sb;
    r.ctype = ct;
    r.coff  = co;
    r.guard = g;
    return r;
  endfunction

  function automatic instr_t prog_rom(input logic [6:0] pc);
    instr_t r;
    case (pc)
      // surface, membrane rigidities
      7'd0:  r = mk(OP_ADD,  S0, O_C1, O_C2, CG, C_NONE, NG);
      7'd1:  r = mk(OP_MUL,  S1, O_C1, O_C2, CG, C_NONE, NG);
      7'd2:  r = mk(OP_SUB,  S2, S0,   O_CF, CG, G_C0, NG);
      7'd3:  r = mk(OP_MUL,  S2, S2,   S2,   CG, C_NONE, NG);
      7'd4:  r = mk(OP_MUL,  S3, O_CF, S2,   CG, G_KAPPA, NG);
      7'd5:  r = mk(OP_MUL,  S4, O_CF, S1,   CG, G_KAPPAG, NG);
      7'd6:  r = mk(OP_SUB,  S3, S3,   S4,   CG, C_NONE, NG);
      7'd7:  r = mk(OP_MUL,  S5, S3,   O_SZ, CG, C_NONE, NG);
      7'd8:  r = mk(OP_TST,  S0, O_CF, S0,   CG, G_KVA, NG);
      7'd9:  r = mk(OP_SUB,  S6, O_SZ, O_CF, CG, G_AV0, GD);
      7'd10: r = mk(OP_MUL,  S6, S6,   S6,   CG, C_NONE, GD);
      7'd11: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_KVA, GD);
      7'd12: r = mk(OP_ADD,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd13: r = mk(OP_END,  S0, S5,   S5,   CG, C_NONE, NG);
      // surface with inclusion
      7'd14: r = mk(OP_ADD,  S0, O_C1, O_C2, CG, C_NONE, NG);
      7'd15: r = mk(OP_MUL,  S1, O_C1, O_C2, CG, C_NONE, NG);
      7'd16: r = mk(OP_SUB,  S2, S0,   O_CF, CT, T_C0, NG);
      7'd17: r = mk(OP_MUL,  S2, S2,   S2,   CG, C_NONE, NG);
      7'd18: r = mk(OP_HALF, S3, O_CF, S0,   CT, T_K, NG);
      7'd19: r = mk(OP_MUL,  S3, S3,   S2,   CG, C_NONE, NG);
      7'd20: r = mk(OP_MUL,  S4, O_CF, S1,   CT, T_KG, NG);
      7'd21: r = mk(OP_SUB,  S3, S3,   S4,   CG, C_NONE, NG);
      7'd22: r = mk(OP_MUL,  S5, S3,   O_SZ, CG, C_NONE, NG);
      7'd23: r = mk(OP_TST,  S0, O_CF, S0,   CT, T_K1, NG);
      7'd24: r = mk(OP_TOR,  S0, O_CF, S0,   CT, T_K2, NG);
      7'd25: r = mk(OP_MUL,  S6, O_DC, O_DC, CG, C_NONE, GD);
      7'd26: r = mk(OP_MUL,  S7, O_DS, O_DS, CG, C_NONE, GD);
      7'd27: r = mk(OP_MUL,  S8, O_C1, S6,   CG, C_NONE, GD);
      7'd28: r = mk(OP_MUL,  S9, O_C2, S7,   CG, C_NONE, GD);
      7'd29: r = mk(OP_ADD,  S8, S8,   S9,   CG, C_NONE, GD);
      7'd30: r = mk(OP_MUL,  S9, O_C2, S6,   CG, C_NONE, GD);
      7'd31: r = mk(OP_MUL,  S10, O_C1, S7,  CG, C_NONE, GD);
      7'd32: r = mk(OP_ADD,  S9, S9,   S10,  CG, C_NONE, GD);
      7'd33: r = mk(OP_SUB,  S8, S8,   O_CF, CT, T_C1, GD);
      7'd34: r = mk(OP_SUB,  S9, S9,   O_CF, CT, T_C2, GD);
      7'd35: r = mk(OP_MUL,  S8, S8,   S8,   CG, C_NONE, GD);
      7'd36: r = mk(OP_MUL,  S9, S9,   S9,   CG, C_NONE, GD);
      7'd37: r = mk(OP_MUL,  S8, O_CF, S8,   CT, T_K1, GD);
      7'd38: r = mk(OP_MUL,  S9, O_CF, S9,   CT, T_K2, GD);
      7'd39: r = mk(OP_ADD,  S8, S8,   S9,   CG, C_NONE, GD);
      7'd40: r = mk(OP_MUL,  S8, S8,   O_SZ, CG, C_NONE, GD);
      7'd41: r = mk(OP_HALF, S8, S8,   S8,   CG, C_NONE, GD);
      7'd42: r = mk(OP_ADD,  S5, S5,   S8,   CG, C_NONE, GD);
      7'd43: r = mk(OP_TST,  S0, O_CF, S0,   CG, G_FIELD, NG);
      7'd44: r = mk(OP_MUL,  S6, O_FC, O_FC, CG, C_NONE, GD);
      7'd45: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_FIELD, GD);
      7'd46: r = mk(OP_SUB,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd47: r = mk(OP_TST,  S0, O_CF, S0,   CG, G_KVA, NG);
      7'd48: r = mk(OP_SUB,  S6, O_SZ, O_CF, CG, G_AV0, GD);
      7'd49: r = mk(OP_MUL,  S6, S6,   S6,   CG, C_NONE, GD);
      7'd50: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_KVA, GD);
      7'd51: r = mk(OP_ADD,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd52: r = mk(OP_END,  S0, S5,   S5,   CG, C_NONE, NG);
      // edge, membrane line tension
      7'd53: r = mk(OP_MUL,  S0, O_C1, O_C1, CG, C_NONE, NG);
      7'd54: r = mk(OP_MUL,  S0, O_CF, S0,   CG, G_KGEDGE, NG);
      7'd55: r = mk(OP_MUL,  S1, O_C2, O_C2, CG, C_NONE, NG);
      7'd56: r = mk(OP_MUL,  S1, O_CF, S1,   CG, G_KNEDGE, NG);
      7'd57: r = mk(OP_ADD,  S0, S0,   S1,   CG, C_NONE, NG);
      7'd58: r = mk(OP_ADD,  S5, O_CF, S0,   CG, G_LAMBDA, NG);
      7'd59: r = mk(OP_MUL,  S5, S5,   O_SZ, CG, C_NONE, NG);
      7'd60: r = mk(OP_TST,  S0, O_CF, S0,   CG, G_KVAEDGE, NG);
      7'd61: r = mk(OP_SUB,  S6, O_SZ, O_CF, CG, G_AV0EDGE, GD);
      7'd62: r = mk(OP_MUL,  S6, S6,   S6,   CG, C_NONE, GD);
      7'd63: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_KVAEDGE, GD);
      7'd64: r = mk(OP_ADD,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd65: r = mk(OP_END,  S0, S5,   S5,   CG, C_NONE, NG);
      // edge with inclusion
      7'd66: r = mk(OP_MUL,  S0, O_C1, O_C1, CG, C_NONE, NG);
      7'd67: r = mk(OP_MUL,  S0, O_CF, S0,   CG, G_KGEDGE, NG);
      7'd68: r = mk(OP_MUL,  S1, O_C2, O_C2, CG, C_NONE, NG);
      7'd69: r = mk(OP_MUL,  S1, O_CF, S1,   CG, G_KNEDGE, NG);
      7'd70: r = mk(OP_ADD,  S0, S0,   S1,   CG, C_NONE, NG);
      7'd71: r = mk(OP_ADD,  S5, O_CF, S0,   CT, T_ELAMBDA, NG);
      7'd72: r = mk(OP_MUL,  S5, S5,   O_SZ, CG, C_NONE, NG);
      7'd73: r = mk(OP_TST,  S0, O_CF, S0,   CT, T_EKN, NG);
      7'd74: r = mk(OP_MUL,  S6, O_DC, O_DC, CG, C_NONE, GD);
      7'd75: r = mk(OP_MUL,  S6, O_CF, S6,   CT, T_EKN, GD);
      7'd76: r = mk(OP_SUB,  S7, O_C2, O_CF, CT, T_ECN, GD);
      7'd77: r = mk(OP_MUL,  S7, S7,   S7,   CG, C_NONE, GD);
      7'd78: r = mk(OP_MUL,  S6, S6,   S7,   CG, C_NONE, GD);
      7'd79: r = mk(OP_MUL,  S6, S6,   O_SZ, CG, C_NONE, GD);
      7'd80: r = mk(OP_ADD,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd81: r = mk(OP_TST,  S0, O_CF, S0,   CG, G_FIELD, NG);
      7'd82: r = mk(OP_MUL,  S6, O_FC, O_FC, CG, C_NONE, GD);
      7'd83: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_FIELD, GD);
      7'd84: r = mk(OP_SUB,  S5, S5,   S6,   CG, C_NONE, GD);
      7'd85: r = mk(OP_TST,  S0, O_CF, S0,   CG, G_KVAEDGE, NG);
      7'd86: r = mk(OP_SUB,  S6, O_SZ, O_CF, CG, G_AV0EDGE, GD);
      7'd87: r = mk(OP_MUL,  S6, S6,   S6,   CG, C_NONE, GD);
      7'd88: r = mk(OP_MUL,  S6, O_CF, S6,   CG, G_KVAEDGE, GD);
      7'd89: r = mk(OP_ADD,  S5, S5,   S6,   CG, C_NONE, GD);
      default: r = mk(OP_END, S0, S5,  S5,   CG, C_NONE, NG);
    endcase
    return r;
  endfunction

endpackage

>>> src/mve_ifs.sv
// valid/ready channel interfaces for the vertex energy block
// no dependencies
interface mve_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         coef_index;
  logic signed [31:0] coef_value;
  logic               is_edge;
  logic               has_inclusion;
  logic [2:0]         type_id;
  logic signed [31:0] curv_first;
  logic signed [31:0] curv_second;
  logic [30:0]        size_measure;
  logic signed [17:0] dir_cos;
  logic signed [17:0] dir_sin;
  logic signed [17:0] field_cos;

  modport source (output valid, command, coef_index, coef_value, is_edge, has_inclusion,
                  type_id, curv_first, curv_second, size_measure, dir_cos, dir_sin,
                  field_cos, input ready);
  modport sink (input valid, command, coef_index, coef_value, is_edge, has_inclusion,
                type_id, curv_first, curv_second, size_measure, dir_cos, dir_sin,
                field_cos, output ready);
endinterface

interface mve_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] energy;
  logic               saturated;

  modport source (output valid, energy, saturated, input ready);
  modport sink (input valid, energy, saturated, output ready);
endinterface

>>> src/mve_ram.sv
// generic ram: one write port, two read ports, registered read data
// no dependencies
module mve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/mve_mul.sv
// fixed-point multiplier: 62x62 magnitude product from four 32x32 partials
// accumulated in turn, truncation toward zero and clipping; uses mve_pkg
module mve_mul
  import mve_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res,
  output logic               clip
);

  logic [61:0]  ua_r, ub_r;
  logic         neg_r;
  logic [2:0]   step_r;
  logic         busy_r;
  logic [63:0]  prod_r;
  logic [1:0]   sh_r;
  logic [123:0] acc_r;
  logic         done_r;
  logic signed [63:0] res_r;
  logic         clip_r;

  logic [63:0]  abs_a, abs_b;
  logic [31:0]  pa, pb;
  logic [123:0] q;
  logic         q_clip;
  logic [63:0]  q_val;

  assign abs_a = a[63] ? 64'(-a) : 64'(a);
  assign abs_b = b[63] ? 64'(-b) : 64'(b);
  // step order: a0b0, a0b1, a1b0, a1b1
  assign pa = step_r[1] ? {2'b00, ua_r[61:32]} : ua_r[31:0];
  assign pb = step_r[0] ? {2'b00, ub_r[61:32]} : ub_r[31:0];
  assign q      = acc_r >> FRAC_BITS;
  assign q_clip = q > 124'(LIM);
  assign q_val  = q_clip ? 64'(LIM) : q[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ua_r  <= abs_a[61:0];
      ub_r  <= abs_b[61:0];
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r <= 3'd3) begin
        prod_r <= pa * pb;
        sh_r   <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + (124'(prod_r) << (7'd32 * 7'(sh_r)));
      end
      if (step_r == 3'd5) begin
        res_r  <= neg_r ? -$signed(q_val) : $signed(q_val);
        clip_r <= q_clip;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign clip = clip_r;

endmodule

>>> src/membrane_vertex_energy.sv
// vertex energy: a microcoded sequencer runs 13 to 39 steps per vertex on one multiplier.
// each vertex is accepted, then each step is fetched and skipped when it is guarded and the
// test flag is clear, else executed; a multiply step forms four 32x32 partial products, and
// the final step waits for the output register to free up.
// a coefficient write leaves the block ready; the block takes no new beat while a vertex runs.
// synchronous active-low reset clears control state and the coefficient valid bits;
// coefficients read as zero until written.
module membrane_vertex_energy
  import mve_pkg::*;
#(
  parameter int TYPE_COUNT = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  mve_in_if.sink   in_ch,
  mve_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_OPER  = 4'b0100,
    ST_MULW  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [6:0] pc_r, pc_nxt;
  logic       flag_r, flag_nxt;
  logic       clip_r, clip_nxt;

  logic signed [31:0] c1_r, c2_r;
  logic [30:0]        sz_r;
  logic signed [17:0] dc_r, ds_r, fc_r;
  logic [2:0]         type_r;

  logic               out_valid_r, out_valid_nxt;
  logic signed [47:0] energy_r, energy_nxt;
  logic               sat_r, sat_nxt;

  logic [COEF_DEPTH-1:0] cvld_r;
  logic                  cvld_q_r;

  instr_t      instr;
  logic [3:0]  tt, tsel;
  logic [7:0]  caddr;
  logic [31:0] coef_rd;
  logic [31:0] coef_unused;
  logic signed [63:0] cval;
  logic [63:0] slot_a, slot_b;
  logic signed [63:0] opa, opb;
  logic        slot_we;
  logic [63:0] slot_wd;
  logic        in_acc;
  logic        mul_start, mul_done, mul_clip;
  logic signed [63:0] mul_res;
  logic signed [64:0] sum;
  logic signed [63:0] sat_val;
  logic        sat_hit;
  logic signed [63:0] half_val;

  assign instr  = prog_rom(pc_r);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // per-type words start at 16 + 16*type
  assign tt    = {1'b0, type_r};
  assign tsel  = (tt >= 4'(TYPE_COUNT)) ? 4'(TYPE_COUNT - 1) : tt;
  assign caddr = instr.ctype ? {4'(tsel + 4'd1), instr.coff} : {4'd0, instr.coff};

  mve_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk     (clk),
    .we      (in_acc && in_ch.command),
    .waddr   (in_ch.coef_index),
    .wdata   (in_ch.coef_value),
    .raddr_a (caddr),
    .rdata_a (coef_rd),
    .raddr_b (caddr),
    .rdata_b (coef_unused)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r   <= '0;
      cvld_q_r <= 1'b0;
    end else begin
      if (in_acc && in_ch.command) begin
        cvld_r[in_ch.coef_index] <= 1'b1;
      end
      cvld_q_r <= cvld_r[caddr];
    end
  end

  assign cval = cvld_q_r ? {{32{coef_rd[31]}}, coef_rd} : 64'sd0;

  mve_ram #(.WIDTH(64), .DEPTH(SLOT_DEPTH)) u_slots (
    .clk     (clk),
    .we      (slot_we),
    .waddr   (instr.dst),
    .wdata   (slot_wd),
    .raddr_a (instr.sa[3:0]),
    .rdata_a (slot_a),
    .raddr_b (instr.sb[3:0]),
    .rdata_b (slot_b)
  );

  function automatic logic signed [63:0] pick(input logic [4:0] code, input logic [63:0] slot,
                                              input logic signed [63:0] cv,
                                              input logic signed [31:0] c1,
                                              input logic signed [31:0] c2,
                                              input logic [30:0] sz,
                                              input logic signed [17:0] dc,
                                              input logic signed [17:0] ds,
                                              input logic signed [17:0] fc);
    logic signed [63:0] v;
    case (code)
      O_C1:    v = {{32{c1[31]}}, c1};
      O_C2:    v = {{32{c2[31]}}, c2};
      O_SZ:    v = {33'd0, sz};
      O_DC:    v = {{46{dc[17]}}, dc};
      O_DS:    v = {{46{ds[17]}}, ds};
      O_FC:    v = {{46{fc[17]}}, fc};
      O_CF:    v = cv;
      default: v = $signed(slot);
    endcase
    return v;
  endfunction

  assign opa = pick(instr.sa, slot_a, cval, c1_r, c2_r, sz_r, dc_r, ds_r, fc_r);
  assign opb = pick(instr.sb, slot_b, cval, c1_r, c2_r, sz_r, dc_r, ds_r, fc_r);

  // add/sub with clipping to +-(2^62-1)
  assign sum = (instr.op == OP_SUB) ? (65'(opa) - 65'(opb)) : (65'(opa) + 65'(opb));
  assign sat_hit = (sum > 65'(LIM)) || (sum < -65'(LIM));
  assign sat_val = (sum > 65'(LIM)) ? LIM : ((sum < -65'(LIM)) ? -LIM : sum[63:0]);
  // halving truncates toward zero
  assign half_val = opa[63] ? -((-opa) >>> 1) : (opa >>> 1);

  assign mul_start = (state_r == ST_OPER) && (instr.op == OP_MUL);

  mve_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .res   (mul_res),
    .clip  (mul_clip)
  );

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    flag_nxt      = flag_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    energy_nxt    = energy_r;
    sat_nxt       = sat_r;
    slot_we       = 1'b0;
    slot_wd       = sat_val;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !in_ch.command) begin
          clip_nxt  = 1'b0;
          flag_nxt  = 1'b0;
          state_nxt = ST_FETCH;
          case ({in_ch.is_edge, in_ch.has_inclusion})
            2'b00:   pc_nxt = PC_SURF;
            2'b01:   pc_nxt = PC_SURF_INC;
            2'b10:   pc_nxt = PC_EDGE;
            default: pc_nxt = PC_EDGE_INC;
          endcase
        end
      end
      ST_FETCH: begin
        if (instr.guard && !flag_r) begin
          pc_nxt = pc_r + 7'd1;
        end else begin
          state_nxt = ST_OPER;
        end
      end
      ST_OPER: begin
        state_nxt = ST_FETCH;
        pc_nxt    = pc_r + 7'd1;
        unique case (instr.op) inside
          OP_ADD, OP_SUB: begin
            slot_we  = 1'b1;
            clip_nxt = clip_r | sat_hit;
          end
          OP_HALF: begin
            slot_we = 1'b1;
            slot_wd = half_val;
          end
          OP_TST: flag_nxt = (opa != 64'sd0);
          OP_TOR: flag_nxt = flag_r | (opa != 64'sd0);
          OP_MUL: begin
            state_nxt = ST_MULW;
            pc_nxt    = pc_r;
          end
          default: begin
            // final step: clip to the output range, wait for a free output register
            pc_nxt = pc_r;
            if (!out_valid_r || out_ch.ready) begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              if (opa > OUT_MAX) begin
                energy_nxt = OUT_MAX[47:0];
                sat_nxt    = 1'b1;
              end else if (opa < OUT_MIN) begin
                energy_nxt = OUT_MIN[47:0];
                sat_nxt    = 1'b1;
              end else begin
                energy_nxt = opa[47:0];
                sat_nxt    = clip_r;
              end
            end else begin
              state_nxt = ST_OPER;
            end
          end
        endcase
      end
      ST_MULW: begin
        if (mul_done) begin
          slot_we   = 1'b1;
          slot_wd   = mul_res;
          clip_nxt  = clip_r | mul_clip;
          pc_nxt    = pc_r + 7'd1;
          state_nxt = ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      flag_r      <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      flag_r      <= flag_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    energy_r <= energy_nxt;
    sat_r    <= sat_nxt;
    if (in_acc && !in_ch.command) begin
      c1_r   <= in_ch.curv_first;
      c2_r   <= in_ch.curv_second;
      sz_r   <= in_ch.size_measure;
      dc_r   <= in_ch.dir_cos;
      ds_r   <= in_ch.dir_sin;
      fc_r   <= in_ch.field_cos;
      type_r <= in_ch.type_id;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.energy    = energy_r;
  assign out_ch.saturated = sat_r;

endmodule

>>> src/mve_checker.sv
// port-level checks of the vertex energy block, bound to the top level
// depends on membrane_vertex_energy_macros.svh
`include "membrane_vertex_energy_macros.svh"

module mve_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_energy
);

  // an evaluate beat makes the block busy
  `MVE_ASSERT_NXT(busy_after_eval, clk, rst_n, in_valid && in_ready && !in_command, !in_ready)
  // a coefficient write leaves the block free
  `MVE_ASSERT_NXT(free_after_write, clk, rst_n, in_valid && in_ready && in_command, in_ready)
  // a new result only appears while a vertex was in flight
  `MVE_ASSERT_IMP(result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))
  // a stalled result holds
  `MVE_ASSERT_NXT(result_holds, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_energy))

endmodule

bind membrane_vertex_energy mve_checker u_mve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_energy (out_ch.energy)
);
